// ===== hdl/series_mean_min_max_sdev_assert.svh =====
// Assertion macros used by the checker of the series statistics block.
`ifndef SERIES_MEAN_MIN_MAX_SDEV_ASSERT_SVH
`define SERIES_MEAN_MIN_MAX_SDEV_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SMMS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define SMMS_ASSERT(lbl, prop, msg) \
    `SMMS_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== hdl/smms_pkg.sv =====
// Shared widths, record types and state codes of the series statistics block.
`default_nettype none

package smms_pkg;

    localparam int SAMPLE_W    = 24;  // Q15.8 sample
    localparam int COUNT_W     = 11;  // sample count
    localparam int SUM_W       = 34;  // signed running sum
    localparam int SQ_W        = 57;  // running sum of squares
    localparam int WIDE_W      = 67;  // n*sumsq, sum^2 and their difference
    localparam int DIV_W       = 21;  // divisor, up to n^2
    localparam int ROOT_W      = 24;  // square root result
    localparam int RAD_W       = 48;  // square root radicand
    localparam int SREM_W      = 26;  // square root partial remainder
    localparam int STEP_W      = 7;   // iteration counter
    localparam int QUEUE_DEPTH = 2;   // series records between front and back
    localparam int QPTR_W      = 1;
    localparam int QFILL_W     = 2;
    localparam int MIN_SDEV_COUNT = 2;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX_VAL = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN_VAL = 24'sh800000;

    typedef struct packed {
        logic        [COUNT_W-1:0]  count;
        logic signed [SUM_W-1:0]    sum;
        logic        [SQ_W-1:0]     sumsq;
        logic signed [SAMPLE_W-1:0] min;
        logic signed [SAMPLE_W-1:0] max;
    } t_series;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL_NQ = 7'b0000010,
        ST_MUL_SS = 7'b0000100,
        ST_DIV_V  = 7'b0001000,
        ST_SQRT   = 7'b0010000,
        ST_DIV_M  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_back_state;

endpackage

`default_nettype wire

// ===== hdl/smms_front.sv =====
// Front part: accepts samples and accumulates count, sum, sum of squares, min and max.
`default_nettype none

module smms_front #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  signed [smms_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire                                   i_last,
    input  smms_pkg::t_queue_stat                 i_stat,
    output logic                                  o_push,
    output smms_pkg::t_series                     o_rec
);
    import smms_pkg::*;

    logic        [COUNT_W-1:0]  r_count, n_count;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic        [SQ_W-1:0]     r_sumsq, n_sumsq;
    logic signed [SAMPLE_W-1:0] r_min, n_min;
    logic signed [SAMPLE_W-1:0] r_max, n_max;
    logic signed [2*SAMPLE_W-1:0] w_sq;
    logic w_take;
    logic w_acc;

    // Stall only a closing beat while the queue has no room.
    assign o_ready = !(i_last && i_stat.full);
    assign w_acc   = i_valid && o_ready;
    assign w_take  = r_count < COUNT_W'(MAX_SAMPLES);
    assign w_sq    = i_sample * i_sample;

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        n_min   = r_min;
        n_max   = r_max;
        if (w_take) begin
            n_count = r_count + 1'b1;
            n_sum   = r_sum + SUM_W'(i_sample);
            n_sumsq = r_sumsq + {{(SQ_W-2*SAMPLE_W){1'b0}}, w_sq};
            if (i_sample < r_min) begin
                n_min = i_sample;
            end
            if (i_sample > r_max) begin
                n_max = i_sample;
            end
        end
    end

    assign o_push      = w_acc && i_last;
    assign o_rec.count = n_count;
    assign o_rec.sum   = n_sum;
    assign o_rec.sumsq = n_sumsq;
    assign o_rec.min   = n_min;
    assign o_rec.max   = n_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_acc && i_last)) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_min   <= SAMPLE_MAX_VAL;
            r_max   <= SAMPLE_MIN_VAL;
        end else if (w_acc) begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sumsq <= n_sumsq;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/smms_queue.sv =====
// Short queue of finished series records between front and back.
`default_nettype none

module smms_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  smms_pkg::t_series      i_wdata,
    input  wire                    i_pop,
    output smms_pkg::t_series      o_rdata,
    output smms_pkg::t_queue_stat  o_stat
);
    import smms_pkg::*;

    t_series r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QFILL_W-1:0] r_fill;
    logic w_push;
    logic w_pop;

    assign o_stat.empty = (r_fill == '0);
    assign o_stat.full  = (r_fill == QFILL_W'(QUEUE_DEPTH));
    assign w_push  = i_push && !o_stat.full;
    assign w_pop   = i_pop && !o_stat.empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/smms_back.sv =====
// Back part: sequencer for products, divisions and square root of one series record.
`default_nettype none

module smms_back (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  smms_pkg::t_queue_stat                 i_stat,
    input  smms_pkg::t_series                     i_rec,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic        [smms_pkg::COUNT_W-1:0]   o_count,
    output logic signed [smms_pkg::SAMPLE_W-1:0]  o_mean,
    output logic signed [smms_pkg::SAMPLE_W-1:0]  o_minimum,
    output logic signed [smms_pkg::SAMPLE_W-1:0]  o_maximum,
    output logic        [smms_pkg::SAMPLE_W-1:0]  o_std_dev
);
    import smms_pkg::*;

    t_back_state r_state, n_state;
    logic [STEP_W-1:0]   r_step;
    t_series             r_rec;
    logic [SQ_W-1:0]     r_mcand;
    logic [SUM_W-1:0]    r_mplr;
    logic [WIDE_W-1:0]   r_prod;
    logic [WIDE_W-1:0]   r_prod_a;
    logic [DIV_W-1:0]    r_div;
    logic [WIDE_W-1:0]   r_num;
    logic [DIV_W:0]      r_rem;
    logic [RAD_W-1:0]    r_rad;
    logic [SREM_W-1:0]   r_srem;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W-1:0]   r_sdev;
    logic [SAMPLE_W-1:0] r_mean;
    logic                r_out_valid;
    logic [COUNT_W-1:0]  r_o_count;
    logic [SAMPLE_W-1:0] r_o_mean;
    logic [SAMPLE_W-1:0] r_o_min;
    logic [SAMPLE_W-1:0] r_o_max;
    logic [SAMPLE_W-1:0] r_o_sdev;

    logic [SUM_W-1:0]  w_mag;
    logic [WIDE_W-1:0] w_prod_nx;
    logic [DIV_W:0]    w_rem_sh;
    logic              w_ge;
    logic [DIV_W:0]    w_rem_nx;
    logic [WIDE_W-1:0] w_num_nx;
    logic [SREM_W-1:0] w_srem_sh;
    logic [SREM_W-1:0] w_trial;
    logic              w_sq_ge;
    logic [SREM_W-1:0] w_srem_nx;
    logic [ROOT_W-1:0] w_root_nx;
    logic              w_var_ok;
    logic [SUM_W-1:0]  w_quo;
    logic [SUM_W-1:0]  w_mean_full;
    logic              w_last_step;
    logic              w_emit;

    assign w_mag = r_rec.sum[SUM_W-1] ? SUM_W'(-r_rec.sum) : SUM_W'(r_rec.sum);

    // Shift-add multiply step, multiplier taken MSB first.
    assign w_prod_nx = {r_prod[WIDE_W-2:0], 1'b0}
                     + (r_mplr[SUM_W-1] ? {{(WIDE_W-SQ_W){1'b0}}, r_mcand} : '0);

    // Restoring divide step, quotient bits shift in at the bottom of r_num.
    assign w_rem_sh = {r_rem[DIV_W-1:0], r_num[WIDE_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_div};
    assign w_rem_nx = w_ge ? w_rem_sh - {1'b0, r_div} : w_rem_sh;
    assign w_num_nx = {r_num[WIDE_W-2:0], w_ge};

    // Digit-by-digit square root step, two radicand bits a step.
    assign w_srem_sh = {r_srem[SREM_W-3:0], r_rad[RAD_W-1:RAD_W-2]};
    assign w_trial   = {r_root, 2'b01};
    assign w_sq_ge   = w_srem_sh >= w_trial;
    assign w_srem_nx = w_sq_ge ? w_srem_sh - w_trial : w_srem_sh;
    assign w_root_nx = {r_root[ROOT_W-2:0], w_sq_ge};

    assign w_var_ok = (r_rec.count >= COUNT_W'(MIN_SDEV_COUNT)) && (r_prod_a >= w_prod_nx);
    assign w_quo       = w_num_nx[SUM_W-1:0];
    assign w_mean_full = r_rec.sum[SUM_W-1] ? -w_quo : w_quo;
    assign w_last_step = (r_step == '0);
    assign w_emit      = (r_state == ST_DONE) && (!r_out_valid || i_ready);
    assign o_pop       = (r_state == ST_IDLE) && !i_stat.empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (!i_stat.empty) n_state = ST_MUL_NQ;
            ST_MUL_NQ: if (w_last_step) n_state = ST_MUL_SS;
            ST_MUL_SS: if (w_last_step) n_state = ST_DIV_V;
            ST_DIV_V:  if (w_last_step) n_state = ST_SQRT;
            ST_SQRT:   if (w_last_step) n_state = ST_DIV_M;
            ST_DIV_M:  if (w_last_step) n_state = ST_DONE;
            ST_DONE:   if (w_emit) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_rec   <= i_rec;
                r_mcand <= i_rec.sumsq;
                r_mplr  <= {i_rec.count, {(SUM_W-COUNT_W){1'b0}}};
                r_prod  <= '0;
                r_step  <= STEP_W'(COUNT_W - 1);
            end
            ST_MUL_NQ: begin
                if (w_last_step) begin
                    r_prod_a <= w_prod_nx;
                    r_prod   <= '0;
                    r_mcand  <= {{(SQ_W-SUM_W){1'b0}}, w_mag};
                    r_mplr   <= w_mag;
                    r_step   <= STEP_W'(SUM_W - 1);
                end else begin
                    r_prod <= w_prod_nx;
                    r_mplr <= r_mplr << 1;
                    r_step <= r_step - 1'b1;
                end
            end
            ST_MUL_SS: begin
                r_prod <= w_prod_nx;
                r_mplr <= r_mplr << 1;
                if (w_last_step) begin
                    // Variance numerator, clamped at zero; n^2 divisor.
                    r_num  <= w_var_ok ? r_prod_a - w_prod_nx : '0;
                    r_div  <= {{(DIV_W-COUNT_W){1'b0}}, r_rec.count}
                            * {{(DIV_W-COUNT_W){1'b0}}, r_rec.count};
                    r_rem  <= '0;
                    r_step <= STEP_W'(WIDE_W - 1);
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            ST_DIV_V: begin
                r_num <= w_num_nx;
                r_rem <= w_rem_nx;
                if (w_last_step) begin
                    r_rad  <= w_num_nx[RAD_W-1:0];
                    r_srem <= '0;
                    r_root <= '0;
                    r_step <= STEP_W'(ROOT_W - 1);
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            ST_SQRT: begin
                r_rad  <= r_rad << 2;
                r_srem <= w_srem_nx;
                r_root <= w_root_nx;
                if (w_last_step) begin
                    r_sdev <= w_root_nx;
                    r_num  <= {w_mag, {(WIDE_W-SUM_W){1'b0}}};
                    r_div  <= {{(DIV_W-COUNT_W){1'b0}}, r_rec.count};
                    r_rem  <= '0;
                    r_step <= STEP_W'(SUM_W - 1);
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            ST_DIV_M: begin
                r_num <= w_num_nx;
                r_rem <= w_rem_nx;
                if (w_last_step) begin
                    r_mean <= w_mean_full[SAMPLE_W-1:0];
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
            ST_DONE: begin
                if (w_emit) begin
                    r_o_count <= r_rec.count;
                    r_o_mean  <= r_mean;
                    r_o_min   <= r_rec.min;
                    r_o_max   <= r_rec.max;
                    r_o_sdev  <= (r_rec.count >= COUNT_W'(MIN_SDEV_COUNT)) ? r_sdev : '0;
                end
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    assign o_valid   = r_out_valid;
    assign o_count   = r_o_count;
    assign o_mean    = r_o_mean;
    assign o_minimum = r_o_min;
    assign o_maximum = r_o_max;
    assign o_std_dev = r_o_sdev;

endmodule

`default_nettype wire

// ===== hdl/series_mean_min_max_sdev.sv =====
// Series statistics top level: count, mean, minimum, maximum and standard deviation.
// Throughput: one sample per cycle, unless a closing beat is held by a full queue.
// The back sequencer takes one series at a time through the shift-add multiplier
//   (11 + 34 steps), the divider (67 + 34 steps) and the root (24 steps).
// Up to two finished series wait in the queue; a closing beat stalls while the queue is full.
// Reset (synchronous, active low) empties the series, the queue and the output register at once.
`default_nettype none

module series_mean_min_max_sdev #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // sample channel
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  signed [smms_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire                                   i_last,
    // result channel
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic        [smms_pkg::COUNT_W-1:0]   o_count,
    output logic signed [smms_pkg::SAMPLE_W-1:0]  o_mean,
    output logic signed [smms_pkg::SAMPLE_W-1:0]  o_minimum,
    output logic signed [smms_pkg::SAMPLE_W-1:0]  o_maximum,
    output logic        [smms_pkg::SAMPLE_W-1:0]  o_std_dev
);
    import smms_pkg::*;

    // Record of a closed series, handed from the front to the queue.
    logic        w_push;
    t_series     w_wrec;
    // Record at the head of the queue, taken by the back sequencer.
    t_series     w_rrec;
    logic        w_pop;
    t_queue_stat w_stat;

    // Accumulate one sample per beat; drop samples beyond MAX_SAMPLES but
    // still close the series on its last beat.
    smms_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .i_last   (i_last),
        .i_stat   (w_stat),
        .o_push   (w_push),
        .o_rec    (w_wrec)
    );

    // Hold closed series while the back is busy with an earlier one.
    smms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wrec),
        .i_pop   (w_pop),
        .o_rdata (w_rrec),
        .o_stat  (w_stat)
    );

    // Work out mean and standard deviation, then hold the result in the
    // output register until the beat is taken.
    smms_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stat    (w_stat),
        .i_rec     (w_rrec),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_count   (o_count),
        .o_mean    (o_mean),
        .o_minimum (o_minimum),
        .o_maximum (o_maximum),
        .o_std_dev (o_std_dev)
    );

endmodule

`default_nettype wire

// ===== hdl/smms_checker.sv =====
// Port-level checks on the result channel of the series statistics block.
`default_nettype none

`include "series_mean_min_max_sdev_assert.svh"

module smms_checker #(
    parameter int MAX_SAMPLES = 1024
) (
    input wire                                   i_clk,
    input wire                                   i_rst_n,
    input wire                                   o_valid,
    input wire                                   i_ready,
    input wire        [smms_pkg::COUNT_W-1:0]    o_count,
    input wire signed [smms_pkg::SAMPLE_W-1:0]   o_mean,
    input wire signed [smms_pkg::SAMPLE_W-1:0]   o_minimum,
    input wire signed [smms_pkg::SAMPLE_W-1:0]   o_maximum,
    input wire        [smms_pkg::SAMPLE_W-1:0]   o_std_dev
);
    import smms_pkg::*;

    `SMMS_ASSERT(a_hold_valid, o_valid && !i_ready |=> o_valid, "result dropped while stalled")
    `SMMS_ASSERT(a_count_range, o_valid |-> o_count != '0 && o_count <= COUNT_W'(MAX_SAMPLES), "count out of range")
    `SMMS_ASSERT(a_short_sdev, o_valid && o_count < COUNT_W'(MIN_SDEV_COUNT) |-> o_std_dev == '0, "nonzero deviation on short series")
    `SMMS_ASSERT(a_mean_bound, o_valid |-> o_minimum <= o_mean && o_mean <= o_maximum, "mean outside min and max")

endmodule

bind series_mean_min_max_sdev smms_checker #(
    .MAX_SAMPLES (MAX_SAMPLES)
) u_smms_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_count   (o_count),
    .o_mean    (o_mean),
    .o_minimum (o_minimum),
    .o_maximum (o_maximum),
    .o_std_dev (o_std_dev)
);

`default_nettype wire

// ===== tb/sv/series_stats_monitor.sv =====
// Monitor for the series statistics block: predicts each series summary and checks result beats.
`timescale 1ns / 100ps

module series_stats_monitor #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample channel, watched
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic signed [smms_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                  i_last,
    // result channel, watched
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic        [smms_pkg::COUNT_W-1:0]   i_count,
    input  logic signed [smms_pkg::SAMPLE_W-1:0]  i_mean,
    input  logic signed [smms_pkg::SAMPLE_W-1:0]  i_minimum,
    input  logic signed [smms_pkg::SAMPLE_W-1:0]  i_maximum,
    input  logic        [smms_pkg::SAMPLE_W-1:0]  i_std_dev,
    // totals for the top
    output int                                    o_errors,
    output int                                    o_pending,
    output int                                    o_beats,
    output int                                    o_results
);
    import smms_pkg::*;

    typedef struct packed {
        logic        [COUNT_W-1:0]  count;
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] maximum;
        logic        [SAMPLE_W-1:0] std_dev;
    } t_summary;

    t_summary pending_summaries[$];

    // running statistics of the open series
    logic        [COUNT_W-1:0]  held_count;
    logic signed [SUM_W-1:0]    held_sum;
    logic        [SQ_W-1:0]     held_sumsq;
    logic signed [SAMPLE_W-1:0] held_min;
    logic signed [SAMPLE_W-1:0] held_max;

    int errors  = 0;
    int beats   = 0;
    int results = 0;

    function automatic void restart_series();
        held_count = '0;
        held_sum   = '0;
        held_sumsq = '0;
        held_min   = SAMPLE_MAX_VAL;
        held_max   = SAMPLE_MIN_VAL;
    endfunction

    // Summary of the open series: truncated mean and floor of the population deviation.
    function automatic t_summary series_summary();
        t_summary           s;
        logic signed [63:0] sum64;
        logic signed [63:0] mean64;
        logic        [63:0] abs_sum;
        logic       [127:0] n_wide;
        logic       [127:0] sumsq_wide;
        logic       [127:0] abs_wide;
        logic       [127:0] scaled_sq;
        logic       [127:0] sum_sq;
        logic       [127:0] variance;
        logic        [31:0] root;
        logic        [31:0] trial;
        sum64      = held_sum;
        abs_sum    = (sum64 < 0) ? -sum64 : sum64;
        n_wide     = held_count;
        sumsq_wide = held_sumsq;
        abs_wide   = abs_sum;
        s.count    = held_count;
        s.minimum  = held_min;
        s.maximum  = held_max;
        mean64     = 0;
        if (held_count != 0) begin
            mean64 = sum64 / longint'(held_count);
        end
        s.mean    = mean64[SAMPLE_W-1:0];
        s.std_dev = '0;
        if (held_count >= MIN_SDEV_COUNT) begin
            scaled_sq = sumsq_wide * n_wide;
            sum_sq    = abs_wide * abs_wide;
            if (scaled_sq >= sum_sq) begin
                variance = (scaled_sq - sum_sq) / (n_wide * n_wide);
                // build the floor root one bit at a time from the top
                root = '0;
                for (int b = 31; b >= 0; b--) begin
                    trial = root | (32'd1 << b);
                    if ({32'd0, trial} * {32'd0, trial} <= variance[63:0]) begin
                        root = trial;
                    end
                end
                s.std_dev = root[SAMPLE_W-1:0];
            end
        end
        return s;
    endfunction

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        logic signed [63:0] wide_sample;
        logic        [63:0] square;
        t_summary           want;
        if (!i_rst_n) begin
            restart_series();
            pending_summaries.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                beats++;
                // drop samples beyond capacity; a closing flag still ends the series
                if (held_count < MAX_SAMPLES) begin
                    wide_sample = i_sample;
                    square      = wide_sample * wide_sample;
                    held_count  = held_count + 1'b1;
                    held_sum    = held_sum + i_sample;
                    held_sumsq  = held_sumsq + square[SQ_W-1:0];
                    if (i_sample < held_min) begin
                        held_min = i_sample;
                    end
                    if (i_sample > held_max) begin
                        held_max = i_sample;
                    end
                end
                if (i_last) begin
                    pending_summaries.push_back(series_summary());
                    restart_series();
                end
            end
            if (i_out_valid && i_out_ready) begin
                results++;
                if (pending_summaries.size() == 0) begin
                    $error("result beat with no series summary pending");
                    errors++;
                end else begin
                    want = pending_summaries.pop_front();
                    compare_field("count", want.count, i_count);
                    compare_field("mean", want.mean, i_mean);
                    compare_field("minimum", want.minimum, i_minimum);
                    compare_field("maximum", want.maximum, i_maximum);
                    compare_field("std_dev", want.std_dev, i_std_dev);
                end
            end
        end
        o_errors  <= errors;
        o_pending <= pending_summaries.size();
        o_beats   <= beats;
        o_results <= results;
    end

endmodule

// ===== tb/sv/series_mean_min_max_sdev_test.sv =====
// Top of the series statistics testbench: clock, reset, sample and result traffic, verdict.
`timescale 1ns / 100ps

module series_mean_min_max_sdev_test;
    import smms_pkg::*;

    localparam int MAX_SAMPLES  = 1024;
    localparam int RESET_CYCLES = 8;
    localparam int IDLE_PCT     = 13;     // chance of an idle cycle on either side
    localparam int RANDOM_BEATS = 700;    // sample beats in the random part
    localparam int OVERRUN      = 6;      // extra samples offered past capacity
    localparam int HOLD_CYCLES  = 1500;   // long hold-off on the result side
    localparam int DRAIN_CYCLES = 250;    // wait after the last summary, watching for stray result beats
    localparam int STALL_LIMIT  = 10000;  // cycles without any beat before giving up
    // stretches in which the sender and the receiver never idle
    localparam int STEADY_FROM  = 600;
    localparam int STEADY_TO    = 1000;
    localparam int CALM_FROM    = 20;
    localparam int CALM_TO      = 40;

    // how the samples of one series are spread
    typedef enum int {
        SPREAD_FULL,     // anywhere in the Q15.8 range
        SPREAD_NARROW,   // a small window around a random center
        SPREAD_EXTREME   // only the range ends, zero and minus one
    } t_spread;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       i_valid   = 1'b0;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample  = '0;
    logic                       i_last    = 1'b0;
    logic                       o_valid;
    logic                       i_ready   = 1'b0;
    logic        [COUNT_W-1:0]  o_count;
    logic signed [SAMPLE_W-1:0] o_mean;
    logic signed [SAMPLE_W-1:0] o_minimum;
    logic signed [SAMPLE_W-1:0] o_maximum;
    logic        [SAMPLE_W-1:0] o_std_dev;

    int mon_errors;
    int mon_pending;
    int mon_beats;
    int mon_results;

    int beats_sent    = 0;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;

    series_mean_min_max_sdev #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sample  (i_sample),
        .i_last    (i_last),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_count   (o_count),
        .o_mean    (o_mean),
        .o_minimum (o_minimum),
        .o_maximum (o_maximum),
        .o_std_dev (o_std_dev)
    );

    series_stats_monitor #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_count     (o_count),
        .i_mean      (o_mean),
        .i_minimum   (o_minimum),
        .i_maximum   (o_maximum),
        .i_std_dev   (o_std_dev),
        .o_errors    (mon_errors),
        .o_pending   (mon_pending),
        .o_beats     (mon_beats),
        .o_results   (mon_results)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Offer one sample beat, with random idle cycles ahead of it, and hold it until taken.
    // Ready is read right after the edge, so it is the value the block had at that edge.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic closing);
        bit steady;
        steady = (beats_sent >= STEADY_FROM) && (beats_sent < STEADY_TO);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        i_last   <= closing;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        beats_sent++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample(
        t_spread spread, logic signed [SAMPLE_W-1:0] center);
        logic signed [SAMPLE_W-1:0] value;
        case (spread)
            SPREAD_FULL: begin
                value = SAMPLE_W'($urandom);
            end
            SPREAD_NARROW: begin
                // wraps at the range ends, which is still a legal sample code
                value = SAMPLE_W'(center + $urandom_range(0, 511) - 256);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       value = SAMPLE_MIN_VAL;
                    1:       value = SAMPLE_MAX_VAL;
                    2:       value = '0;
                    default: value = '1;
                endcase
            end
        endcase
        return value;
    endfunction

    // Send one whole series; samples past capacity switch to extremes so that
    // any of them wrongly taken in would show up in the minimum or maximum.
    task automatic send_series(input int len, input t_spread spread);
        logic signed [SAMPLE_W-1:0] center;
        t_spread                    now_spread;
        center = SAMPLE_W'($urandom);
        for (int k = 0; k < len; k++) begin
            now_spread = spread;
            if (k >= MAX_SAMPLES) begin
                now_spread = SPREAD_EXTREME;
            end
            send_sample(draw_sample(now_spread, center), k == len - 1);
        end
    endtask

    // Result side: random stalls, one long hold-off, and a calm stretch with none.
    initial begin : result_sink
        int  taken;
        bit  stall;
        taken = 0;
        wait (i_rst_n);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                // hold ready low while the sender keeps offering, so the block fills
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end
            stall = !(taken >= CALM_FROM && taken < CALM_TO) &&
                    ($urandom_range(0, 99) < IDLE_PCT);
            i_ready <= !stall;
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                taken++;
            end
        end
    end

    // Give up when neither channel moves a beat for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("no beat on either channel for %0d cycles", STALL_LIMIT);
        $display("series_mean_min_max_sdev test failed");
        $finish;
    end

    initial begin : stimulus
        int random_start;
        int pick;
        int len;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-sample series: deviation forced to zero
        send_sample('0, 1'b1);
        send_sample(SAMPLE_MAX_VAL, 1'b1);
        send_sample(SAMPLE_MIN_VAL, 1'b1);
        // both range ends: widest spread, mean truncates toward zero
        send_sample(SAMPLE_MIN_VAL, 1'b0);
        send_sample(SAMPLE_MAX_VAL, 1'b1);
        // constant series: zero variance at the range ends
        send_sample(SAMPLE_MAX_VAL, 1'b0);
        send_sample(SAMPLE_MAX_VAL, 1'b1);
        send_sample(SAMPLE_MIN_VAL, 1'b0);
        send_sample(SAMPLE_MIN_VAL, 1'b0);
        send_sample(SAMPLE_MIN_VAL, 1'b1);
        // negative and positive odd sums: truncation of the mean
        send_sample(-24'sd3, 1'b0);
        send_sample(-24'sd2, 1'b1);
        send_sample(24'sd3, 1'b0);
        send_sample(24'sd2, 1'b1);
        // alternating bit patterns
        send_sample(24'sh555555, 1'b0);
        send_sample(24'shAAAAAA, 1'b0);
        send_sample('0, 1'b1);
        // 1.0 to 4.0 in Q15.8
        send_sample(24'sd256, 1'b0);
        send_sample(24'sd512, 1'b0);
        send_sample(24'sd768, 1'b0);
        send_sample(24'sd1024, 1'b1);

        // random part: mostly short series, a few long ones
        hold_off_req = 1'b1;
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                len = 1;
            end else if (pick < 70) begin
                len = $urandom_range(2, 24);
            end else if (pick < 95) begin
                len = $urandom_range(25, 120);
            end else begin
                len = $urandom_range(121, 400);
            end
            send_series(len, t_spread'($urandom_range(0, 2)));
        end
        // a series that fills capacity and then runs past it
        send_series(MAX_SAMPLES + OVERRUN, SPREAD_NARROW);
        i_valid <= 1'b0;

        // drain: wait for every predicted summary, then watch for strays
        @(posedge i_clk);
        while (mon_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d sample beats and %0d series results,", mon_beats, mon_results);
        $display("  with range ends, constant, over-long series and a %0d-cycle result hold-off.",
                 HOLD_CYCLES);
        if (mon_errors == 0) begin
            $display("series_mean_min_max_sdev test passed");
        end else begin
            $display("series_mean_min_max_sdev test failed");
        end
        $finish;
    end

endmodule
